// ===== hw/rtl/hsxd_pkg.sv =====
// Package for the header sync XOR deframer.
// Holds the header constants, the reset frame length and the result beat type.
// No dependencies.
package hsxd_pkg;

	localparam logic [7:0] HDR_BYTE0  = 8'hBD;
	localparam logic [7:0] HDR_BYTE1  = 8'hDB;
	localparam logic [7:0] HDR_BYTE2  = 8'h04;
	localparam logic [7:0] HDR_LEN    = 8'd3;
	localparam logic [7:0] LEN_NORMAL = 8'd54;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic [7:0] byte_offset;
		logic       last_byte;
		logic       check_ok;
	} result_t;

endpackage

// ===== hw/rtl/hsxd_in_stage.sv =====
// Input register stage of the deframer.
// Captures one received byte per beat and holds it until the sync stage takes it.
// Depends on nothing but the clock and reset.
module hsxd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic vld_s1;

	assign in_ready = !vld_s1 || advance;
	assign valid_s1 = vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

// ===== hw/rtl/hsxd_sync.sv =====
// Header hunt, frame counter and XOR checksum of the deframer.
// Holds the frame length register and the hunt state; builds the result beat.
// Depends on hsxd_pkg.
module hsxd_sync (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [7:0]       cfg_data,
	input  logic             en,
	input  logic [7:0]       rx_byte,
	output logic             res_valid,
	output hsxd_pkg::result_t res
);

	import hsxd_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_GOT0,
		PH_GOT1,
		PH_FRAME
	} phase_t;

	phase_t     phase_q;
	phase_t     phase_d;
	logic [7:0] count_q;
	logic [7:0] count_d;
	logic [7:0] xor_q;
	logic [7:0] xor_d;
	logic [7:0] frame_length_q;
	logic       last;

	assign last = ({1'b0, count_q} + 9'd1) >= {1'b0, frame_length_q};

	always_comb begin
		phase_d   = phase_q;
		count_d   = count_q;
		xor_d     = xor_q;
		res_valid = 1'b0;
		res       = '{frame_byte: rx_byte, byte_offset: count_q, last_byte: last,
			check_ok: last && (xor_q == rx_byte)};
		unique case (phase_q)
			PH_IDLE: begin
				count_d = '0;
				if (rx_byte == HDR_BYTE0) begin
					phase_d = PH_GOT0;
					xor_d   = HDR_BYTE0;
				end else begin
					xor_d   = '0;
				end
			end
			PH_GOT0: begin
				if (rx_byte == HDR_BYTE1) begin
					phase_d = PH_GOT1;
					xor_d   = xor_q ^ rx_byte;
				end else if (rx_byte == HDR_BYTE0) begin
					phase_d = PH_GOT0;
					count_d = '0;
					xor_d   = HDR_BYTE0;
				end else begin
					phase_d = PH_IDLE;
					count_d = '0;
					xor_d   = '0;
				end
			end
			PH_GOT1: begin
				if (rx_byte == HDR_BYTE2) begin
					phase_d = PH_FRAME;
					xor_d   = xor_q ^ rx_byte;
					count_d = HDR_LEN;
				end else if (rx_byte == HDR_BYTE0) begin
					phase_d = PH_GOT0;
					count_d = '0;
					xor_d   = HDR_BYTE0;
				end else begin
					phase_d = PH_IDLE;
					count_d = '0;
					xor_d   = '0;
				end
			end
			PH_FRAME: begin
				res_valid = en;
				if (last) begin
					phase_d = PH_IDLE;
					count_d = '0;
					xor_d   = '0;
				end else begin
					xor_d   = xor_q ^ rx_byte;
					count_d = count_q + 8'd1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			count_q        <= '0;
			xor_q          <= '0;
			frame_length_q <= LEN_NORMAL;
		end else begin
			if (en) begin
				phase_q <= phase_d;
				count_q <= count_d;
				xor_q   <= xor_d;
			end
			if (cfg_valid) begin
				frame_length_q <= cfg_data;
			end
		end
	end

endmodule

// ===== hw/rtl/hsxd_out_stage.sv =====
// Output register stage of the deframer.
// Holds one result beat until the downstream side takes it.
// Depends on hsxd_pkg.
module hsxd_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  hsxd_pkg::result_t res,
	output logic              advance,
	output logic              out_valid,
	input  logic              out_ready,
	output hsxd_pkg::result_t out_res
);

	import hsxd_pkg::*;

	logic vld_q;

	assign advance   = !vld_q || out_ready;
	assign out_valid = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (out_ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_res <= res;
		end
	end

endmodule

// ===== hw/rtl/header_sync_xor_deframer.sv =====
// Header sync XOR deframer, top level.
// A frame byte is registered in the input stage, its result beat in the output stage.
// Throughput: one byte per cycle if m_tready is high; single input and output registers.
// Reset: arst_n clears the hunt state, the checksum and both valid flags,
// and sets the frame length to 54.
module header_sync_xor_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] frame_byte, [15:8] byte_offset
	output logic        m_tlast,   // last_byte
	output logic        m_tuser,   // check_ok
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // frame_length
);

	import hsxd_pkg::*;

	logic       advance;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       en;
	logic       res_valid;
	result_t    res;
	result_t    out_res;

	assign cfg_ready = 1'b1;
	assign en        = valid_s1 && advance;

	hsxd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	hsxd_sync u_sync (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.en        (en),
		.rx_byte   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	hsxd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.advance   (advance),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	assign m_tdata = {out_res.byte_offset, out_res.frame_byte};
	assign m_tlast = out_res.last_byte;
	assign m_tuser = out_res.check_ok;

endmodule

// ===== test/hsxd_checker.sv =====
// Checker for the header sync XOR deframer: watches the input, output and length-write
// channels, predicts every output beat from the accepted input beats and compares them.
// Depends on hsxd_pkg for the header constants and the result beat type.
`timescale 1ns / 1ps

module hsxd_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,   // [7:0] frame_byte, [15:8] byte_offset
	input  logic        m_tlast,   // last_byte
	input  logic        m_tuser,   // check_ok
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [7:0]  cfg_data,  // frame_length
	output int          errors,
	output int          pending,
	output int          results_seen,
	output int          frames_closed,
	output int          frames_good
);

	import hsxd_pkg::*;

	typedef enum logic [1:0] {SEEK, SAW_BD, SAW_BD_DB, IN_FRAME} sync_t;

	sync_t      sync_state;
	logic [7:0] next_offset;
	logic [7:0] frame_xor;
	logic [7:0] frame_len;
	result_t    frame_byte_q[$];
	int         fail_count = 0;
	int         queued = 0;
	int         n_results = 0;
	int         n_closed = 0;
	int         n_good = 0;

	assign errors        = fail_count;
	assign pending       = queued;
	assign results_seen  = n_results;
	assign frames_closed = n_closed;
	assign frames_good   = n_good;

	task automatic report(input string msg);
		$display("%0d ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic restart_match();
		sync_state = SAW_BD;
		next_offset = '0;
		frame_xor = HDR_BYTE0;
	endtask

	task automatic drop_match();
		sync_state = SEEK;
		next_offset = '0;
		frame_xor = '0;
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		result_t r;
		logic    closing;
		case (sync_state)
			SEEK: begin
				if (b == HDR_BYTE0) restart_match();
				else drop_match();
			end
			SAW_BD: begin
				if (b == HDR_BYTE1) begin
					sync_state = SAW_BD_DB;
					frame_xor = frame_xor ^ b;
				end else if (b == HDR_BYTE0) restart_match();
				else drop_match();
			end
			SAW_BD_DB: begin
				if (b == HDR_BYTE2) begin
					sync_state = IN_FRAME;
					frame_xor = frame_xor ^ b;
					next_offset = HDR_LEN;
				end else if (b == HDR_BYTE0) restart_match();
				else drop_match();
			end
			default: begin
				closing = ({1'b0, next_offset} + 9'd1) >= {1'b0, frame_len};
				r.frame_byte = b;
				r.byte_offset = next_offset;
				r.last_byte = closing;
				r.check_ok = closing && (frame_xor == b);
				frame_byte_q = {frame_byte_q, r};
				if (closing) drop_match();
				else begin
					frame_xor = frame_xor ^ b;
					next_offset = next_offset + 8'd1;
				end
			end
		endcase
	endtask

	task automatic check_beat();
		result_t want;
		if (frame_byte_q.size() == 0) begin
			report($sformatf("output beat %04h with no beat expected", m_tdata));
			return;
		end
		want = frame_byte_q.pop_front();
		n_results++;
		if (m_tdata[7:0] !== want.frame_byte)
			report($sformatf("frame_byte %02h, expected %02h", m_tdata[7:0], want.frame_byte));
		if (m_tdata[15:8] !== want.byte_offset)
			report($sformatf("byte_offset %0d, expected %0d", m_tdata[15:8], want.byte_offset));
		if (m_tlast !== want.last_byte)
			report($sformatf("last_byte %b, expected %b at offset %0d", m_tlast,
				want.last_byte, want.byte_offset));
		if (m_tuser !== want.check_ok)
			report($sformatf("check_ok %b, expected %b at offset %0d", m_tuser,
				want.check_ok, want.byte_offset));
		if (want.last_byte) begin
			n_closed++;
			if (want.check_ok) n_good++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_match();
			frame_len = LEN_NORMAL;
			frame_byte_q.delete();
			queued <= 0;
		end else begin
			if (cfg_valid && cfg_ready) frame_len = cfg_data;
			if (m_tvalid && m_tready) check_beat();
			if (s_tvalid && s_tready) deframe_byte(s_tdata);
			queued <= frame_byte_q.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// Top of the deframer testbench: clock, reset, byte stimulus, output back-pressure and
// frame length writes, with hsxd_checker beside the block doing all checking.
// Depends on hsxd_pkg, header_sync_xor_deframer and hsxd_checker.
`timescale 1ns / 1ps

module tb_top;
	import hsxd_pkg::*;

	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;   // [7:0] frame_byte, [15:8] byte_offset
	logic        m_tlast;   // last_byte
	logic        m_tuser;   // check_ok
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;  // frame_length

	int   errors, pending, results_seen, frames_closed, frames_good;
	int   bytes_sent = 0;
	int   lengths_used = 1;
	bit   sender_gaps = 1'b1;
	bit   calm = 1'b0;
	bit   hold_done = 1'b0;
	logic hold_req = 1'b0;

	header_sync_xor_deframer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	hsxd_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tlast       (m_tlast),
		.m_tuser       (m_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending),
		.results_seen  (results_seen),
		.frames_closed (frames_closed),
		.frames_good   (frames_good)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#6_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Output side: random stall bursts, one long hold-off on request, none at the end.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (sender_gaps && !calm && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(input int len, input bit good);
		logic [7:0] sum;
		logic [7:0] b;
		int         last_off;
		sum = HDR_BYTE0 ^ HDR_BYTE1 ^ HDR_BYTE2;
		last_off = (len <= 4) ? 3 : len - 1;
		send_byte(HDR_BYTE0);
		send_byte(HDR_BYTE1);
		send_byte(HDR_BYTE2);
		for (int off = 3; off < last_off; off++) begin
			b = 8'($urandom_range(0, 255));
			send_byte(b);
			sum = sum ^ b;
		end
		send_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
	endtask

	function automatic logic [7:0] noise_byte();
		logic [7:0] v;
		case ($urandom_range(0, 5))
			0: v = HDR_BYTE0;
			1: v = HDR_BYTE1;
			2: v = HDR_BYTE2;
			default: v = 8'($urandom_range(0, 255));
		endcase
		return v;
	endfunction

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_length(input logic [7:0] len);
		cfg_valid <= 1'b1;
		cfg_data <= len;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		lengths_used++;
	endtask

	task automatic run_phase(input int len, input int budget);
		int stop_at;
		drain();
		write_length(8'(len));
		stop_at = bytes_sent + budget;
		while (bytes_sent < stop_at) begin
			case ($urandom_range(0, 19)) inside
				[0:13]: send_frame(len, $urandom_range(0, 6) != 0);
				[14:16]: repeat ($urandom_range(1, 6)) send_byte(noise_byte());
				default: begin
					send_byte(HDR_BYTE0);
					if ($urandom_range(0, 1)) send_byte(HDR_BYTE1);
					send_byte($urandom_range(0, 3) == 0 ? HDR_BYTE0 : noise_byte());
				end
			endcase
		end
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		cfg_valid <= 1'b0;
		cfg_data <= 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hunting bytes, broken headers, a repeated 0xBD, then one frame at the reset length.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(HDR_BYTE1);
		send_byte(HDR_BYTE2);
		send_byte(HDR_BYTE0);
		send_byte(8'h77);
		send_byte(HDR_BYTE0);
		send_byte(HDR_BYTE1);
		send_byte(8'h55);
		send_byte(HDR_BYTE0);
		send_byte(HDR_BYTE1);
		send_byte(HDR_BYTE0);
		send_frame(LEN_NORMAL, 1'b1);

		// Frames of length 5 with a good and a bad checksum, then a length below the header.
		drain();
		write_length(8'd5);
		send_byte(HDR_BYTE0);
		send_frame(5, 1'b1);
		send_frame(5, 1'b0);
		drain();
		write_length(8'd0);
		send_frame(0, 1'b1);
		send_frame(4, 1'b0);

		run_phase(58, 250);
		run_phase(5, 150);
		run_phase(6, 100);
		run_phase($urandom_range(7, 30), 150);
		run_phase($urandom_range(7, 30), 150);

		// Longest frame while the output side holds off, so the block must stall its input.
		drain();
		write_length(8'd255);
		sender_gaps = 1'b0;
		hold_req <= 1'b1;
		send_frame(255, 1'b1);
		sender_gaps = 1'b1;
		send_frame(255, 1'b0);

		run_phase($urandom_range(7, 30), 150);
		calm = 1'b1;
		run_phase(LEN_NORMAL, 200);

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d input beats under %0d frame length settings.", bytes_sent,
			lengths_used);
		$display("Checked %0d output beats, %0d frames closed, %0d with a matching checksum.",
			results_seen, frames_closed, frames_good);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
